// ----- sv/llsm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package llsm_pkg;

	localparam int KEY_CARD_LEDS    = 76;
	localparam int KEY_CARD_LATCHES = 16;
	localparam int TOTAL_LEDS       = 144;
	localparam int NUM_LATCHES      = 35;
	localparam int IDX_W            = $clog2(NUM_LATCHES);
	localparam logic [7:0] LED_ALL  = 8'd255;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MODIFY,
		ST_BCAST
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic mstep;
		logic bstep;
	} dp_cmd_t;

	typedef struct packed {
		logic bcast;
		logic emits;
		logic out_free;
		logic bcnt_end;
	} dp_sts_t;

	typedef struct packed {
		logic       emit;
		idx_t       idx;
		logic [7:0] mask;
		logic [7:0] val;
	} led_map_t;

	function automatic logic [7:0] off_byte(idx_t k);
		if (k < idx_t'(30))
			return 8'd255;
		else if (k < idx_t'(34))
			return 8'd0;
		else
			return 8'd119;
	endfunction

	function automatic logic [7:0] bcast_byte(idx_t k, logic [2:0] st);
		logic [7:0] s;
		logic [7:0] d;
		s = {8{st[0]}};
		d = 8'(({5'b0, st} + 8'd252) * 8'd85);
		if (st == 3'd7)
			return off_byte(k);
		if (k < idx_t'(KEY_CARD_LATCHES)) begin
			case (k)
				idx_t'(0), idx_t'(1), idx_t'(8),
				idx_t'(13), idx_t'(14), idx_t'(15): return s;
				default: return d;
			endcase
		end
		if (k < idx_t'(30))
			return d;
		if (k < idx_t'(34))
			return ~d;
		return (st == 3'd5) ? 8'd0 : 8'd119;
	endfunction

	// Single LED: target latch, bits touched and their new values.
	function automatic led_map_t map_led(logic [2:0] st, logic [7:0] led);
		led_map_t   m;
		logic       on57;
		logic [1:0] bp;
		logic [2:0] b;
		logic [7:0] t;
		logic [7:0] num;
		logic [7:0] adj;
		logic       ic;
		m    = '0;
		on57 = (st == 3'd5) || (st == 3'd7);
		bp   = 2'd0;
		b    = 3'd0;
		num  = led - 8'd75;
		t    = 8'd0;
		adj  = 8'd0;
		ic   = 1'b0;
		if (led < 8'(KEY_CARD_LEDS)) begin
			if (led >= 8'd16 && led <= 8'd38) begin
				bp = led[1:0];
				m.emit = 1'b1;
				m.idx = idx_t'(3'(led[7:2] + 6'd6));
				m.mask = 8'(8'd3 << {bp, 1'b0});
				m.val = 8'({6'b0, st[1], st[0]} << {bp, 1'b0});
			end else if (led >= 8'd45 && led <= 8'd59) begin
				t = led - 8'd45;
				bp = t[1:0];
				m.emit = 1'b1;
				m.idx = idx_t'(8) + idx_t'(3'(t[7:2] + 6'd1));
				m.mask = 8'(8'd3 << {bp, 1'b0});
				m.val = 8'({6'b0, st[1], st[0]} << {bp, 1'b0});
			end else if (on57 && led != 8'd39) begin
				m.emit = 1'b1;
				if (led < 8'd16) begin
					b = led[2:0];
					m.idx = idx_t'(led[3]);
				end else if (led == 8'd40) begin
					b = 3'd4;
					m.idx = idx_t'(8);
				end else if (led <= 8'd44) begin
					t = led - 8'd1;
					b = t[2:0];
					m.idx = idx_t'(8);
				end else if (led <= 8'd65) begin
					t = led - 8'd4;
					b = t[2:0];
					m.idx = idx_t'(13);
				end else begin
					t = led - 8'd2;
					b = t[2:0];
					m.idx = idx_t'(8) + idx_t'(3'(t[7:3] - 5'd2));
				end
				m.mask = 8'(8'd1 << b);
				m.val = 8'({7'b0, st[1]} << b);
			end
		end else if (led < 8'(TOTAL_LEDS)) begin
			m.emit = 1'b1;
			m.idx = idx_t'(KEY_CARD_LATCHES);
			if (led <= 8'd129) begin
				ic = (num >= 8'd32);
				adj = ic ? num : num - 8'd1;
				bp = adj[1:0];
				m.idx = idx_t'(KEY_CARD_LATCHES) + idx_t'({ic, adj[4:2]});
				m.mask = 8'(8'd3 << {bp, 1'b0});
				m.val = 8'({6'b0, st[1], st[0]} << {bp, 1'b0});
			end else if (led == 8'd130 || led == 8'd131 || led == 8'd133 ||
			             led == 8'd134 || led == 8'd136 || led == 8'd137 ||
			             led == 8'd139 || led == 8'd140) begin
				case (led)
					8'd130, 8'd131: m.idx = idx_t'(30);
					8'd133, 8'd134: m.idx = idx_t'(31);
					8'd136, 8'd137: m.idx = idx_t'(32);
					default:        m.idx = idx_t'(33);
				endcase
				case (led)
					8'd131, 8'd134, 8'd137, 8'd140: bp = 2'd1;
					default:                        bp = 2'd0;
				endcase
				m.mask = 8'(8'd3 << {bp, 1'b0});
				m.val = 8'({6'b0, ~st[1], ~st[0]} << {bp, 1'b0});
			end else if ((led == 8'd142 || led == 8'd143) && on57) begin
				b = (led == 8'd143) ? 3'd4 : 3'd0;
				m.idx = idx_t'(34);
				m.mask = 8'(8'd7 << b);
				m.val = {8{st[1]}} & m.mask;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- sv/llsm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module llsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 35
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- sv/llsm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module llsm_ctrl
	import llsm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.bcast)
						state_d = ST_BCAST;
					else if (sts.emits)
						state_d = ST_MODIFY;
				end
			end
			ST_MODIFY: begin
				if (sts.out_free)
					state_d = ST_IDLE;
			end
			ST_BCAST: begin
				if (sts.out_free && sts.bcnt_end)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MODIFY: cmd.mstep = sts.out_free;
			ST_BCAST:  cmd.bstep = sts.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- sv/llsm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module llsm_dp
	import llsm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_cmd_t    cmd,
	output dp_sts_t         sts,
	input  wire logic [2:0] colour_state,
	input  wire logic [7:0] led_number,
	input  wire logic       out_ready,
	output logic            out_valid,
	output logic            card,
	output logic      [2:0] chip,
	output logic      [2:0] latch,
	output logic      [7:0] data,
	output logic            last
);

	led_map_t               map_in;
	led_map_t               map_q;
	logic [2:0]             st_q;
	idx_t                   bcnt_q;
	logic [NUM_LATCHES-1:0] valid_q;
	logic [7:0]             rdata;
	logic [7:0]             base;
	logic [7:0]             wdata;
	idx_t                   waddr;
	logic                   emit;
	logic                   out_valid_q;
	logic                   card_q;
	logic [2:0]             chip_q;
	logic [2:0]             latch_q;
	logic [7:0]             data_q;
	logic                   last_q;

	assign map_in = map_led(colour_state, led_number);
	assign emit   = cmd.mstep | cmd.bstep;

	// Untouched shadow entries read as the all-off pattern.
	assign base = valid_q[map_q.idx] ? rdata : off_byte(map_q.idx);

	always_comb begin
		if (cmd.bstep) begin
			waddr = bcnt_q;
			wdata = bcast_byte(bcnt_q, st_q);
		end else begin
			waddr = map_q.idx;
			wdata = (base & ~map_q.mask) | (map_q.val & map_q.mask);
		end
	end

	llsm_ram #(
		.WIDTH(8),
		.DEPTH(NUM_LATCHES)
	) u_shadow (
		.clk  (clk),
		.we   (emit),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.load),
		.raddr(map_in.idx),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			map_q <= map_in;
			st_q  <= colour_state;
		end
		if (emit) begin
			card_q  <= (waddr >= idx_t'(KEY_CARD_LATCHES));
			chip_q  <= waddr[IDX_W-1:3];
			latch_q <= waddr[2:0];
			data_q  <= wdata;
			last_q  <= cmd.mstep || (bcnt_q == idx_t'(NUM_LATCHES - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q      <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				bcnt_q <= '0;
			else if (cmd.bstep)
				bcnt_q <= sts.bcnt_end ? '0 : bcnt_q + idx_t'(1);
			if (emit)
				valid_q[waddr] <= 1'b1;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign sts.bcast    = (led_number == LED_ALL);
	assign sts.emits    = map_in.emit;
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.bcnt_end = (bcnt_q == idx_t'(NUM_LATCHES - 1));

	assign out_valid = out_valid_q;
	assign card      = card_q;
	assign chip      = chip_q;
	assign latch     = latch_q;
	assign data      = data_q;
	assign last      = last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while stalled");

	a_bcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q < idx_t'(NUM_LATCHES))
		else $error("broadcast counter out of range");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mstep && cmd.bstep) && !(cmd.load && emit))
		else $error("conflicting datapath commands");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && cmd.bstep && sts.bcnt_end) |=> (out_valid_q && last_q))
		else $error("broadcast did not end with last");

endmodule

`default_nettype wire

// ----- sv/led_latch_shadow_mapper.sv -----
// Keeps a shadow of the panel's 35 output latches (16 key card, 19 bus card)
// in a small RAM and turns each LED request into latch writes on the
// card/chip/latch/data outputs, with last marking the final write of a
// request. For a single LED, the accept cycle reads the shadow byte; once
// the output register is free, the modify state merges the new bits, writes
// it back and loads the output register; a new request is taken the cycle
// after. LED number 255 takes the accept cycle and then 35 latch writes, one
// per cycle while the output is not stalled, through the single shadow write
// port. Requests that map to no latch finish in the accept cycle with no
// write. A stalled output holds the block in place. Shadow entries not yet
// written read as the all-off pattern, so no clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module led_latch_shadow_mapper
	import llsm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] colour_state,
	input  wire logic [7:0] led_number,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            card,
	output logic      [2:0] chip,
	output logic      [2:0] latch,
	output logic      [7:0] data,
	output logic            last
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	llsm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	llsm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.colour_state(colour_state),
		.led_number  (led_number),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.card        (card),
		.chip        (chip),
		.latch       (latch),
		.data        (data),
		.last        (last)
	);

endmodule

`default_nettype wire
